/* hw/rtl/irm_pkg.sv */
package irm_pkg;

  localparam int FRAME_WIDTH_DEF  = 1024;
  localparam int FRAME_HEIGHT_DEF = 512;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_REMAP = 1'b1;

  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_BILINEAR = 2'd1;
  localparam logic [1:0] MODE_BICUBIC  = 2'd2;

  localparam logic [15:0] ONE_Q14 = 16'd16384;

  typedef logic [3:0][255:0][15:0] cubic_tab_t;

  typedef struct packed {
    logic             is_write;
    logic [1:0]       mode;
    logic [7:0]       pix;
    logic [3:0][9:0]  cols;
    logic [3:0][8:0]  rows;
    logic [3:0][15:0] wx;
    logic [3:0][15:0] wy;
  } irm_entry_t;

  // cubic lagrange weights in q2.14, rounded to nearest, ties away from zero
  function automatic cubic_tab_t cubic_table();
    cubic_tab_t tab;
    longint t, t1, t2, t3, n, mag, q;
    for (int f = 0; f < 256; f++) begin
      t  = longint'(f);
      t1 = t * 65536;
      t2 = t * t * 256;
      t3 = t * t * t;
      for (int k = 0; k < 4; k++) begin
        unique case (k)
          0: n = -2 * t1 + 3 * t2 - t3;
          1: n = 6 * 16777216 - 3 * t1 - 6 * t2 + 3 * t3;
          2: n = 6 * t1 + 3 * t2 - 3 * t3;
          default: n = -t1 + t3;
        endcase
        mag = (n < 0) ? -n : n;
        q = (mag + 3072) / 6144;
        if (n < 0) q = -q;
        tab[k][f] = q[15:0];
      end
    end
    return tab;
  endfunction

  localparam cubic_tab_t CUBIC_TAB = cubic_table();

endpackage

/* hw/rtl/irm_ram.sv */
module irm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/irm_queue.sv */
module irm_queue import irm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  irm_entry_t push_data,
  input  logic       pop,
  output irm_entry_t head,
  output logic       empty,
  output logic       full
);

  irm_entry_t entries_r [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_r, count_nxt;

  function automatic logic [$clog2(QUEUE_DEPTH)-1:0] ptr_inc(
    input logic [$clog2(QUEUE_DEPTH)-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count_r == '0);
  assign full  = (int'(count_r) == QUEUE_DEPTH);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + {{($clog2(QUEUE_DEPTH+1)-1){1'b0}}, push}
                 - {{($clog2(QUEUE_DEPTH+1)-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/irm_front.sv */
module irm_front import irm_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic            accept,
  input  logic [1:0]      mode,
  input  logic            req_type,
  input  logic [7:0]      pix_value,
  input  logic [3:0][9:0] cols,
  input  logic [3:0][8:0] rows,
  input  logic [7:0]      frac_x,
  input  logic [7:0]      frac_y,
  output logic            push,
  output irm_entry_t      entry
);

  logic wr_in_plane;

  assign wr_in_plane = (int'(cols[0]) < FRAME_WIDTH) && (int'(rows[0]) < FRAME_HEIGHT);

  always_comb begin
    entry.is_write = (req_type == REQ_WRITE);
    entry.mode     = mode;
    entry.pix      = pix_value;
    entry.cols     = cols;
    entry.rows     = rows;
    entry.wx       = '0;
    entry.wy       = '0;
    priority if (mode == MODE_NEAREST) begin
      entry.wx[1] = ONE_Q14;
      entry.wy[1] = ONE_Q14;
    end else if (mode == MODE_BILINEAR) begin
      entry.wx[1] = {1'b0, 9'd256 - {1'b0, frac_x}, 6'b0};
      entry.wx[2] = {2'b0, frac_x, 6'b0};
      entry.wy[1] = {1'b0, 9'd256 - {1'b0, frac_y}, 6'b0};
      entry.wy[2] = {2'b0, frac_y, 6'b0};
    end else begin
      // mode three runs as bicubic
      for (int k = 0; k < 4; k++) begin
        entry.wx[k] = CUBIC_TAB[k][frac_x];
        entry.wy[k] = CUBIC_TAB[k][frac_y];
      end
    end
  end

  // out-of-range writes are dropped here and never reach the back end
  assign push = accept && ((req_type != REQ_WRITE) || wr_in_plane);

endmodule

/* hw/rtl/irm_back.sv */
module irm_back import irm_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  irm_entry_t    head,
  input  logic          empty,
  output logic          pop,
  output logic          ram_we,
  output logic          rd_en,
  output logic [AW-1:0] ram_addr,
  output logic [7:0]    ram_wdata,
  input  logic [7:0]    ram_rdata,
  output logic          out_valid,
  output logic [7:0]    out_pixel
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TAPS  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]         state_r, state_nxt;
  irm_entry_t         ent_r, ent_nxt;
  logic [1:0]         i_r, i_nxt, j_r, j_nxt, lo_r, lo_nxt, last_r, last_nxt;
  logic               s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic signed [31:0] wprod_r, wprod_nxt;
  logic signed [18:0] w2_r, w2_nxt;
  logic [7:0]         pix_r;
  logic signed [31:0] acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_pixel_r, out_pixel_nxt;
  logic [31:0]        mag;
  logic [17:0]        q;
  logic [31:0]        v;

  function automatic logic [AW-1:0] pix_addr(input logic [8:0] row, input logic [9:0] col);
    logic [AW-1:0] r, c;
    r = (int'(row) > FRAME_HEIGHT - 1) ? AW'(FRAME_HEIGHT - 1) : AW'(row);
    c = (int'(col) > FRAME_WIDTH - 1) ? AW'(FRAME_WIDTH - 1) : AW'(col);
    return AW'(r * AW'(FRAME_WIDTH)) + c;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    last_nxt      = last_r;
    s1_v_nxt      = 1'b0;
    s2_v_nxt      = s1_v_r;
    wprod_nxt     = wprod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_pixel_nxt = out_pixel_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    rd_en         = 1'b0;
    ram_addr      = pix_addr(ent_r.rows[i_r], ent_r.cols[j_r]);
    ram_wdata     = head.pix;

    // round the 2-d weight back to q2.14, ties away from zero
    mag    = wprod_r[31] ? 32'(-wprod_r) : 32'(wprod_r);
    q      = 18'((mag + 32'd8192) >> 14);
    w2_nxt = wprod_r[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});

    if (s2_v_r) begin
      acc_nxt = acc_r + 32'(w2_r) * $signed({24'b0, pix_r});
    end

    v = 32'(acc_r);
    if (ent_r.mode == MODE_BILINEAR) begin
      v = (v + 32'd8192) >> 14;
    end else begin
      v = v >> 14;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.is_write) begin
            ram_we   = 1'b1;
            ram_addr = pix_addr(head.rows[0], head.cols[0]);
          end else begin
            ent_nxt   = head;
            acc_nxt   = '0;
            state_nxt = ST_TAPS;
            priority if (head.mode == MODE_NEAREST) begin
              lo_nxt = 2'd1; last_nxt = 2'd1;
            end else if (head.mode == MODE_BILINEAR) begin
              lo_nxt = 2'd1; last_nxt = 2'd2;
            end else begin
              lo_nxt = 2'd0; last_nxt = 2'd3;
            end
            i_nxt = lo_nxt;
            j_nxt = lo_nxt;
          end
        end
      end
      ST_TAPS: begin
        rd_en     = 1'b1;
        s1_v_nxt  = 1'b1;
        wprod_nxt = 32'($signed(ent_r.wy[i_r])) * 32'($signed(ent_r.wx[j_r]));
        if (j_r == last_r) begin
          j_nxt = lo_r;
          if (i_r == last_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + 2'd1;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          out_valid_nxt = 1'b1;
          if (acc_r <= 0) begin
            out_pixel_nxt = '0;
          end else begin
            out_pixel_nxt = (v > 32'd255) ? 8'd255 : v[7:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    lo_r        <= lo_nxt;
    last_r      <= last_nxt;
    wprod_r     <= wprod_nxt;
    w2_r        <= w2_nxt;
    pix_r       <= ram_rdata;
    acc_r       <= acc_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

/* hw/rtl/image_remap_interpolator.sv */
// Remaps a frame store of 8-bit pixels into interpolated output pixels. A write item
// (in_req_type 0) stores in_pix_value at row in_row_0, column in_col_0; writes outside
// the plane are dropped. A request item (in_req_type 1) returns one pixel on out_pixel,
// flagged by a one-cycle out_valid pulse that the receiver must take as it comes, in
// item order. Items enter when start is high and busy low; a two-entry queue sits
// between the input and the execution unit. The execution unit reads the frame store
// through a single port, one tap per cycle: a nearest request reads one tap, bilinear
// four and bicubic 16 taps, followed by pipeline fill and the result. Taps beyond
// the plane saturate to the last row or column.
// Never-written entries read back undefined. cfg_data sets the mode (0 nearest,
// 1 bilinear, 2 or 3 bicubic); write it only while the block is idle.
module image_remap_interpolator import irm_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [7:0] in_pix_value,
  input  logic [9:0] in_col_0,
  input  logic [9:0] in_col_1,
  input  logic [9:0] in_col_2,
  input  logic [9:0] in_col_3,
  input  logic [8:0] in_row_0,
  input  logic [8:0] in_row_1,
  input  logic [8:0] in_row_2,
  input  logic [8:0] in_row_3,
  input  logic [7:0] in_frac_x,
  input  logic [7:0] in_frac_y,
  output logic       out_valid,
  output logic [7:0] out_pixel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0]    mode_r;
  logic          push, pop, empty, full, ram_we, rd_en;
  irm_entry_t    entry, head;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BILINEAR;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  irm_front #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
    .accept    (start && !busy),
    .mode      (mode_r),
    .req_type  (in_req_type),
    .pix_value (in_pix_value),
    .cols      ({in_col_3, in_col_2, in_col_1, in_col_0}),
    .rows      ({in_row_3, in_row_2, in_row_1, in_row_0}),
    .frac_x    (in_frac_x),
    .frac_y    (in_frac_y),
    .push      (push),
    .entry     (entry)
  );

  irm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  irm_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .ram_we    (ram_we),
    .rd_en     (rd_en),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  irm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && rd_en))
    else $error("frame store written and read in one cycle");

  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results closer than one item apart");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

endmodule

/* tb/sv/image_remap_interpolator_checker.sv */
`timescale 1ns / 1ps

module image_remap_interpolator_checker import irm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_req_type,
  input  logic [7:0] in_pix_value,
  input  logic [9:0] in_col_0,
  input  logic [9:0] in_col_1,
  input  logic [9:0] in_col_2,
  input  logic [9:0] in_col_3,
  input  logic [8:0] in_row_0,
  input  logic [8:0] in_row_1,
  input  logic [8:0] in_row_2,
  input  logic [8:0] in_row_3,
  input  logic [7:0] in_frac_x,
  input  logic [7:0] in_frac_y,
  input  logic       out_valid,
  input  logic [7:0] out_pixel,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [7:0] pixel_mem [int];
  logic [7:0] pixels_due [$];
  logic [1:0] cur_mode;
  int         result_idx;

  function automatic int mem_addr(int row, int col);
    if (col > FRAME_WIDTH_DEF - 1) col = FRAME_WIDTH_DEF - 1;
    if (row > FRAME_HEIGHT_DEF - 1) row = FRAME_HEIGHT_DEF - 1;
    return row * FRAME_WIDTH_DEF + col;
  endfunction

  // divide, nearest with ties away from zero
  function automatic longint div_round(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic void lagrange_taps(int f, output longint w [4]);
    longint t, t1, t2, t3;
    t  = f;
    t1 = t * 65536;
    t2 = t * t * 256;
    t3 = t * t * t;
    w[0] = div_round(-2 * t1 + 3 * t2 - t3, 6144);
    w[1] = div_round(64'sd100663296 - 3 * t1 - 6 * t2 + 3 * t3, 6144);
    w[2] = div_round(6 * t1 + 3 * t2 - 3 * t3, 6144);
    w[3] = div_round(t3 - t1, 6144);
  endfunction

  function automatic logic [7:0] remap_pixel(int rows [4], int cols [4], int fx, int fy);
    longint wx [4], wy [4];
    longint acc, w, v;
    int lo, hi;
    acc = 0;
    if (cur_mode == MODE_NEAREST) return pixel_mem[mem_addr(rows[1], cols[1])];
    if (cur_mode == MODE_BILINEAR) begin
      wx = '{0, (256 - fx) * 64, fx * 64, 0};
      wy = '{0, (256 - fy) * 64, fy * 64, 0};
      lo = 1;
      hi = 3;
    end else begin
      lagrange_taps(fx, wx);
      lagrange_taps(fy, wy);
      lo = 0;
      hi = 4;
    end
    for (int i = lo; i < hi; i++)
      for (int j = lo; j < hi; j++) begin
        w = div_round(wy[i] * wx[j], 16384);
        acc += w * longint'(pixel_mem[mem_addr(rows[i], cols[j])]);
      end
    if (acc <= 0) v = 0;
    else if (cur_mode == MODE_BILINEAR) v = (acc + 8192) >>> 14;
    else v = acc >>> 14;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  always @(posedge clk) begin
    int rows [4];
    int cols [4];
    logic [7:0] want;
    if (!rst_n) begin
      cur_mode   = MODE_BILINEAR;
      fail_count = 0;
      result_idx = 0;
      pixels_due.delete();
      pending    = 0;
    end else begin
      if (out_valid) begin
        if (pixels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: out_pixel %0d with no item pending", result_idx, out_pixel);
        end else begin
          want = pixels_due.pop_front();
          if (out_pixel !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: out_pixel expected %0d got %0d",
                       result_idx, want, out_pixel);
          end
        end
        result_idx++;
      end
      if (cfg_valid && cfg_ready) cur_mode = cfg_data;
      if (start && !busy) begin
        if (in_req_type == REQ_WRITE) begin
          if (in_col_0 < FRAME_WIDTH_DEF && in_row_0 < FRAME_HEIGHT_DEF)
            pixel_mem[mem_addr(in_row_0, in_col_0)] = in_pix_value;
        end else begin
          rows = '{in_row_0, in_row_1, in_row_2, in_row_3};
          cols = '{in_col_0, in_col_1, in_col_2, in_col_3};
          pixels_due.push_back(remap_pixel(rows, cols, in_frac_x, in_frac_y));
        end
      end
      pending = pixels_due.size();
    end
  end

endmodule

/* tb/sv/image_remap_interpolator_tb.sv */
`timescale 1ns / 1ps

module image_remap_interpolator_tb import irm_pkg::*;;

  localparam logic [1:0] MODE_BICUBIC_ALT = 2'd3;
  localparam int         DRAIN_CYCLES     = 64;

  typedef struct {
    logic            kind;
    logic [7:0]      pix;
    logic [3:0][9:0] cols;
    logic [3:0][8:0] rows;
    logic [7:0]      fx;
    logic [7:0]      fy;
  } remap_item_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  remap_item_t cur;
  logic        out_valid;
  logic [7:0]  out_pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  int          fail_count;
  int          pending;
  int unsigned items_taken;
  int unsigned cfg_taken;
  int          item_no;
  int          grid_rows [$];
  int          grid_cols [$];

  image_remap_interpolator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(cur.kind), .in_pix_value(cur.pix),
    .in_col_0(cur.cols[0]), .in_col_1(cur.cols[1]),
    .in_col_2(cur.cols[2]), .in_col_3(cur.cols[3]),
    .in_row_0(cur.rows[0]), .in_row_1(cur.rows[1]),
    .in_row_2(cur.rows[2]), .in_row_3(cur.rows[3]),
    .in_frac_x(cur.fx), .in_frac_y(cur.fy),
    .out_valid(out_valid), .out_pixel(out_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  image_remap_interpolator_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(cur.kind), .in_pix_value(cur.pix),
    .in_col_0(cur.cols[0]), .in_col_1(cur.cols[1]),
    .in_col_2(cur.cols[2]), .in_col_3(cur.cols[3]),
    .in_row_0(cur.rows[0]), .in_row_1(cur.rows[1]),
    .in_row_2(cur.rows[2]), .in_row_3(cur.rows[3]),
    .in_frac_x(cur.fx), .in_frac_y(cur.fy),
    .out_valid(out_valid), .out_pixel(out_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // handshake counters, settled by the following falling edge
  always @(posedge clk) begin
    if (!rst_n) begin
      items_taken <= 0;
      cfg_taken   <= 0;
    end else begin
      if (start && !busy) items_taken <= items_taken + 1;
      if (cfg_valid && cfg_ready) cfg_taken <= cfg_taken + 1;
    end
  end

  initial begin
    #5ms;
    $display("image_remap_interpolator_tb: errors");
    $finish;
  end

  // called at a falling edge; returns at a falling edge after acceptance, at times after a random pause with start low
  task automatic send(remap_item_t it);
    int unsigned seen;
    seen  = items_taken;
    start <= 1'b1;
    cur   <= it;
    do @(negedge clk); while (items_taken == seen);
    item_no++;
    if ((item_no < 250 || item_no > 360) && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic write_pixel(int row, int col, logic [7:0] value);
    remap_item_t it;
    it.kind = REQ_WRITE;
    it.pix  = value;
    it.cols = {10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
               10'($urandom_range(0, 1023)), 10'(col)};
    it.rows = {9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
               9'($urandom_range(0, 511)), 9'(row)};
    it.fx   = 8'($urandom_range(0, 255));
    it.fy   = 8'($urandom_range(0, 255));
    send(it);
  endtask

  task automatic request(int r [4], int c [4], int fx, int fy);
    remap_item_t it;
    it.kind = REQ_REMAP;
    it.pix  = 8'($urandom_range(0, 255));
    for (int k = 0; k < 4; k++) begin
      it.cols[k] = 10'(c[k]);
      it.rows[k] = 9'(r[k]);
    end
    it.fx = 8'(fx);
    it.fy = 8'(fy);
    send(it);
  endtask

  // idle until every pending result is out and the unit has finished any write
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(logic [1:0] mode);
    int unsigned seen;
    settle();
    seen      = cfg_taken;
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(negedge clk); while (cfg_taken == seen);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic extreme_requests();
    int r [4];
    int c [4];
    for (int k = 0; k < 4; k++) begin
      r[k] = grid_rows[k];
      c[k] = grid_cols[k];
    end
    request(r, c, 0, 0);
    request(r, c, 255, 255);
    request(r, c, 128, 1);
    request(r, c, 1, 128);
  endtask

  // every grid row/column pair stays written, so any tap pick reads known data
  task automatic random_items(int count);
    int r [4];
    int c [4];
    int roll, v;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6 && grid_rows.size() < 10) begin
        do v = $urandom_range(0, 511); while (v inside {grid_rows});
        grid_rows.push_back(v);
        foreach (grid_cols[j]) write_pixel(v, grid_cols[j], pick_value());
      end else if (roll < 12 && grid_cols.size() < 10) begin
        do v = $urandom_range(0, 1023); while (v inside {grid_cols});
        grid_cols.push_back(v);
        foreach (grid_rows[i]) write_pixel(grid_rows[i], v, pick_value());
      end else if (roll < 35) begin
        write_pixel(grid_rows[$urandom_range(0, grid_rows.size() - 1)],
                    grid_cols[$urandom_range(0, grid_cols.size() - 1)], pick_value());
      end else begin
        for (int k = 0; k < 4; k++) begin
          r[k] = grid_rows[$urandom_range(0, grid_rows.size() - 1)];
          c[k] = grid_cols[$urandom_range(0, grid_cols.size() - 1)];
        end
        request(r, c, $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    logic [1:0] modes [5];
    rst_n     = 1'b0;
    start     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = MODE_BILINEAR;
    cur       = '{kind: REQ_WRITE, pix: 8'd0, cols: '0, rows: '0, fx: 8'd0, fy: 8'd0};
    item_no   = 0;
    modes     = '{MODE_NEAREST, MODE_BICUBIC, MODE_BICUBIC_ALT, MODE_BILINEAR, MODE_BICUBIC};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // checkerboard of the extremes, read back first in the bilinear mode that reset leaves
    grid_rows = '{0, 1, 2, 511};
    grid_cols = '{0, 1, 2, 1023};
    foreach (grid_rows[i])
      foreach (grid_cols[j])
        write_pixel(grid_rows[i], grid_cols[j], ((i + j) % 2) ? 8'd255 : 8'd0);
    extreme_requests();

    foreach (modes[m]) begin
      set_mode(modes[m]);
      extreme_requests();
      random_items(110);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("image_remap_interpolator_tb: clean");
    end else begin
      $display("image_remap_interpolator_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/irm_pkg.sv
hw/rtl/irm_ram.sv
hw/rtl/irm_queue.sv
hw/rtl/irm_front.sv
hw/rtl/irm_back.sv
hw/rtl/image_remap_interpolator.sv
tb/sv/image_remap_interpolator_checker.sv
tb/sv/image_remap_interpolator_tb.sv
